FILE: design/qd_pkg.sv
package qd_pkg;

   localparam int TABLE_BITS   = 9;
   localparam int TABLE_SIZE   = 1 << TABLE_BITS;
   localparam int ADDR_BITS    = TABLE_BITS + 1;
   localparam int SAMPLE_WIDTH = 16;
   localparam int PHASE_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int ROM_WIDTH    = 16;

   localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [ROM_WIDTH-1:0] rom_type [0:TABLE_SIZE];

   typedef struct packed {
      logic load;
      logic rom_rd;
      logic rom_cos;
      logic interp_en;
      logic mix_q_en;
      logic out_load;
   } qd_cmd_type;

   // restoring long division, used only while the table is built
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // quadrant folding plus q30 taylor series, evaluated at elaboration only
   function automatic rom_type build_rom();
      rom_type            rom;
      logic [63:0]        a;
      logic [63:0]        q;
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        div;
      logic signed [63:0] sum;
      logic [63:0]        mag;
      for (int k = 0; k <= TABLE_SIZE; k++) begin
         a = 64'(4 * k);
         q = (a >> TABLE_BITS) & 64'd3;
         r = a & 64'(TABLE_SIZE - 1);
         if (q[0]) begin
            r = 64'(TABLE_SIZE) - r;
         end
         x = (r * HALF_PI_Q30 + 64'(TABLE_SIZE / 2)) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         term = x;
         sum = $signed(x);
         for (int i = 1; i <= 12; i++) begin
            div = 64'((2 * i) * (2 * i + 1));
            term = div_u64((term * x2) >> 30, div);
            if ((i % 2) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         mag = ($unsigned(sum) + 64'd16384) >> 15;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         rom[k] = q[1] ? -$signed(mag[ROM_WIDTH-1:0]) : $signed(mag[ROM_WIDTH-1:0]);
      end
      return rom;
   endfunction

endpackage

FILE: design/qd_if.sv
interface qd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [qd_pkg::SAMPLE_WIDTH-1:0] sample;
   logic                                first_of_block;

   modport source (output valid, output sample, output first_of_block, input ready);
   modport sink   (input valid, input sample, input first_of_block, output ready);
endinterface

interface qd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [qd_pkg::SAMPLE_WIDTH-1:0] i_out;
   logic signed [qd_pkg::SAMPLE_WIDTH-1:0] q_out;

   modport source (output valid, output i_out, output q_out, input ready);
   modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

interface qd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [qd_pkg::PHASE_WIDTH-1:0]     phase_step;

   modport source (output valid, output phase_step, input ready);
   modport sink   (input valid, input phase_step, output ready);
endinterface

FILE: design/qd_ctrl.sv
module qd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output qd_pkg::qd_cmd_type cmd
);
   import qd_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RD_SIN  = 3'd1;
   localparam logic [2:0] ST_RD_COS  = 3'd2;
   localparam logic [2:0] ST_MIX_SIN = 3'd3;
   localparam logic [2:0] ST_MIX_COS = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RD_SIN;
            end
         end
         ST_RD_SIN: begin
            cmd.rom_rd = 1'b1;
            state_in = ST_RD_COS;
         end
         ST_RD_COS: begin
            cmd.rom_rd = 1'b1;
            cmd.rom_cos = 1'b1;
            cmd.interp_en = 1'b1;
            state_in = ST_MIX_SIN;
         end
         ST_MIX_SIN: begin
            cmd.interp_en = 1'b1;
            cmd.mix_q_en = 1'b1;
            state_in = ST_MIX_COS;
         end
         ST_MIX_COS: begin
            // wait here until the output register can take the result
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/qd_dp.sv
module qd_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  qd_pkg::qd_cmd_type                     cmd,
   input  logic signed [qd_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic                                   first_of_block,
   input  logic                                   csr_write,
   input  logic [qd_pkg::PHASE_WIDTH-1:0]         csr_data,
   output logic signed [qd_pkg::SAMPLE_WIDTH-1:0] i_out,
   output logic signed [qd_pkg::SAMPLE_WIDTH-1:0] q_out
);
   import qd_pkg::*;

   localparam rom_type SINE_ROM = build_rom();
   localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH;

   logic [PHASE_WIDTH-1:0]         step_ff;
   logic [PHASE_WIDTH-1:0]         acc_ff;
   logic [PHASE_WIDTH-1:0]         phase_ff;
   logic [PHASE_WIDTH-1:0]         phase_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;

   logic [PHASE_WIDTH-1:0]         look_phase;
   logic [TABLE_BITS-1:0]          idx;
   logic [ADDR_BITS-1:0]           idx_next;
   logic signed [ROM_WIDTH-1:0]    rom_a_ff;
   logic signed [ROM_WIDTH-1:0]    rom_b_ff;
   logic [FRAC_BITS-1:0]           frac_ff;

   logic signed [ROM_WIDTH:0]                 diff;
   logic signed [ROM_WIDTH+FRAC_BITS+1:0]     interp_prod;
   logic signed [ROM_WIDTH+1:0]               interp_sum;
   logic signed [ROM_WIDTH-1:0]               interp_ff;

   logic signed [PROD_WIDTH-1:0]   mix_prod;
   logic signed [PROD_WIDTH-16:0]  mix_shift;
   logic signed [SAMPLE_WIDTH-1:0] mix_sat;
   logic signed [SAMPLE_WIDTH-1:0] q_hold_ff;
   logic signed [SAMPLE_WIDTH-1:0] i_out_ff;
   logic signed [SAMPLE_WIDTH-1:0] q_out_ff;

   localparam logic signed [PROD_WIDTH-16:0] SAT_HI =
      (PROD_WIDTH - 15)'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [PROD_WIDTH-16:0] SAT_LO = -SAT_HI - 2'sd1;

   assign phase_in = first_of_block ? '0 : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (csr_write) begin
            step_ff <= csr_data;
         end
         if (cmd.load) begin
            acc_ff <= phase_in + step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         phase_ff <= phase_in;
         sample_ff <= sample;
      end
   end

   // table address and interpolation fraction from the top phase bits
   assign look_phase = cmd.rom_cos ? phase_ff + QUARTER_TURN : phase_ff;
   assign idx = look_phase[PHASE_WIDTH-1 -: TABLE_BITS];
   assign idx_next = {1'b0, idx} + ADDR_BITS'(1);

   always_ff @(posedge clock) begin
      if (cmd.rom_rd) begin
         rom_a_ff <= SINE_ROM[{1'b0, idx}];
         rom_b_ff <= SINE_ROM[idx_next];
         frac_ff <= look_phase[PHASE_WIDTH-1-TABLE_BITS -: FRAC_BITS];
      end
   end

   // a + floor((b - a) * f / 2^16)
   assign diff = {rom_b_ff[ROM_WIDTH-1], rom_b_ff} - {rom_a_ff[ROM_WIDTH-1], rom_a_ff};
   assign interp_prod = diff * $signed({1'b0, frac_ff});
   assign interp_sum = {{2{rom_a_ff[ROM_WIDTH-1]}}, rom_a_ff}
                     + interp_prod[ROM_WIDTH+FRAC_BITS+1 -: ROM_WIDTH+2];

   always_ff @(posedge clock) begin
      if (cmd.interp_en) begin
         interp_ff <= interp_sum[ROM_WIDTH-1:0];
      end
   end

   assign mix_prod = sample_ff * interp_ff;
   assign mix_shift = mix_prod[PROD_WIDTH-1:15];

   always_comb begin
      priority if (mix_shift > SAT_HI) begin
         mix_sat = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (mix_shift < SAT_LO) begin
         mix_sat = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         mix_sat = mix_shift[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_q_en) begin
         q_hold_ff <= mix_sat;
      end
      if (cmd.out_load) begin
         i_out_ff <= mix_sat;
         q_out_ff <= q_hold_ff;
      end
   end

   assign i_out = i_out_ff;
   assign q_out = q_out_ff;

endmodule

FILE: design/quadrature_demodulator.sv
// a request passes the states RD_SIN, RD_COS, MIX_SIN and MIX_COS, and waits in
// MIX_COS until the output register is free; a new request is taken only in idle;
// the sine table has two read ports, and sine and cosine are read from it in turn,
// then share one interpolation multiplier and one mixing multiplier
// reset clears phase_step, the phase accumulator and all handshake state
module quadrature_demodulator (
   input logic      clock,
   input logic      reset,
   qd_req_if.sink   req_ch,
   qd_rsp_if.source rsp_ch,
   qd_csr_if.sink   csr_ch
);
   import qd_pkg::*;

   qd_cmd_type cmd;
   logic       csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write = csr_ch.valid;

   qd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   qd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sample         (req_ch.sample),
      .first_of_block (req_ch.first_of_block),
      .csr_write      (csr_write),
      .csr_data       (csr_ch.phase_step),
      .i_out          (rsp_ch.i_out),
      .q_out          (rsp_ch.q_out)
   );

endmodule

FILE: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 100;

   localparam logic [PHASE_WIDTH-1:0] DIRECTED_STEPS [4] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0080
   };
   localparam logic signed [SAMPLE_WIDTH-1:0] EDGE_SAMPLES [6] = '{
      16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh4000
   };

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] i_val;
      logic signed [SAMPLE_WIDTH-1:0] q_val;
   } iq_pair_type;

   class iq_scoreboard;
      rom_type                sine_lut;
      logic [PHASE_WIDTH-1:0] step;
      logic [PHASE_WIDTH-1:0] phase;
      iq_pair_type            iq_due[$];
      int                     errors;

      function new();
         longint unsigned a, quad, rem, x, x2, term, mag;
         longint          s;
         step = '0;
         phase = '0;
         errors = 0;
         // fold each table point into the first quadrant, q30 taylor series
         for (int k = 0; k <= TABLE_SIZE; k++) begin
            a = 4 * k;
            quad = (a / TABLE_SIZE) & 3;
            rem = a % TABLE_SIZE;
            if ((quad & 1) != 0) begin
               rem = TABLE_SIZE - rem;
            end
            x = (rem * HALF_PI_Q30 + TABLE_SIZE / 2) / TABLE_SIZE;
            x2 = (x * x) >> 30;
            term = x;
            s = x;
            for (int i = 1; i <= 12; i++) begin
               term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
               if ((i % 2) == 1) begin
                  s = s - term;
               end else begin
                  s = s + term;
               end
            end
            if (s < 0) begin
               s = 0;
            end
            mag = (s + 16384) >> 15;
            if (mag > 32767) begin
               mag = 32767;
            end
            sine_lut[k] = ((quad & 2) != 0) ? -mag[ROM_WIDTH-1:0] : mag[ROM_WIDTH-1:0];
         end
      endfunction

      // linear interpolation between neighboring table points
      function longint sine_at(logic [PHASE_WIDTH-1:0] p);
         int unsigned idx;
         longint      frac, lo_val, hi_val;
         idx = p[PHASE_WIDTH-1 -: TABLE_BITS];
         frac = p[PHASE_WIDTH-1-TABLE_BITS -: FRAC_BITS];
         lo_val = sine_lut[idx];
         hi_val = sine_lut[idx+1];
         return (lo_val * (65536 - frac) + hi_val * frac) >>> FRAC_BITS;
      endfunction

      function logic signed [SAMPLE_WIDTH-1:0] mix_product(logic signed [SAMPLE_WIDTH-1:0] smp,
                                                           longint s);
         longint v;
         longint hi_lim;
         hi_lim = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
         v = (longint'(smp) * s) >>> 15;
         if (v > hi_lim) begin
            v = hi_lim;
         end
         if (v < -hi_lim - 1) begin
            v = -hi_lim - 1;
         end
         return v[SAMPLE_WIDTH-1:0];
      endfunction

      function void take_sample(logic signed [SAMPLE_WIDTH-1:0] smp, logic first);
         iq_pair_type            pair;
         logic [PHASE_WIDTH-1:0] p;
         if (first) begin
            phase = '0;
         end
         p = phase;
         pair.i_val = mix_product(smp, sine_at(p + QUARTER_TURN));
         pair.q_val = mix_product(smp, sine_at(p));
         iq_due.push_back(pair);
         phase = p + step;
      endfunction

      function void check_iq(logic signed [SAMPLE_WIDTH-1:0] i_got,
                             logic signed [SAMPLE_WIDTH-1:0] q_got);
         iq_pair_type want;
         if (iq_due.size() == 0) begin
            $display("%0t: unexpected response i_out %0d q_out %0d", $time, i_got, q_got);
            errors++;
         end else begin
            want = iq_due.pop_front();
            if (i_got !== want.i_val) begin
               $display("%0t: i_out expected %0d actual %0d", $time, want.i_val, i_got);
               errors++;
            end
            if (q_got !== want.q_val) begin
               $display("%0t: q_out expected %0d actual %0d", $time, want.q_val, q_got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return iq_due.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int unsigned  cycle_count = 0;
   iq_scoreboard sb;

   qd_req_if req_ch();
   qd_rsp_if rsp_ch();
   qd_csr_if csr_ch();

   quadrature_demodulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_iq(rsp_ch.i_out, rsp_ch.q_out);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample <= smp;
      req_ch.first_of_block <= first;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      sb.take_sample(smp, first);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [PHASE_WIDTH-1:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.phase_step <= value;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      sb.step = value;
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [PHASE_WIDTH-1:0]        step_val;
      logic signed [SAMPLE_WIDTH-1:0] smp;
      sb = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.sample <= '0;
      req_ch.first_of_block <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.phase_step <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // extremes of the sample, wrapping steps, steps past a half turn
      for (int c = 0; c < 4; c++) begin
         if (c > 0) begin
            write_step(DIRECTED_STEPS[c]);
         end
         for (int j = 0; j < 6; j++) begin
            send_sample(EDGE_SAMPLES[j], (j == 0) || (j == 4));
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 36;
               recv_stall_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_stall_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int ph = 0; ph < 3; ph++) begin
            case (mode * 3 + ph)
               0: step_val = 32'hFFFF_FFFF;
               1: step_val = 32'h8000_0000;
               2: step_val = $urandom_range(1, 4096);
               3: step_val = 32'h0000_0000;
               4: step_val = $urandom;
               5: step_val = 32'h7FFF_FFFF;
               6: step_val = 32'h0000_0001;
               7: step_val = $urandom;
               default: step_val = 32'h4000_0000;
            endcase
            write_step(step_val);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               if ($urandom_range(9) == 0) begin
                  smp = EDGE_SAMPLES[$urandom_range(5)];
               end else begin
                  smp = SAMPLE_WIDTH'($urandom);
               end
               send_sample(smp, $urandom_range(11) == 0);
            end
         end
      end

      drain();
      if (sb.pending() != 0) begin
         $display("%0t: %0d responses never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/qd_pkg.sv
design/qd_if.sv
design/qd_ctrl.sv
design/qd_dp.sv
design/quadrature_demodulator.sv
dv/tb_top.sv
